// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checks sampled on clock, off during reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`endif

// ===== sv/mrwt_pkg.sv =====
package mrwt_pkg;
   localparam logic [1:0] VERDICT_BELOW_TWO = 2'd0;
   localparam logic [1:0] VERDICT_TWO       = 2'd1;
   localparam logic [1:0] VERDICT_COMPOSITE = 2'd2;
   localparam logic [1:0] VERDICT_PROBABLE  = 2'd3;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_SHIFT,
      OP_REDUCE,
      OP_MUL_RES,
      OP_MUL_SQ,
      OP_SQR_CUR,
      OP_TAKE_POW
   } op_type;

   typedef struct packed {
      op_type     op;
   } cmd_type;

   typedef struct packed {
      logic       mul_busy;
      logic       small_n;
      logic       n_is_two;
      logic       n_even;
      logic       x_odd;
      logic       x_zero;
      logic       twos_zero;
      logic       cur_is_one;
      logic       nontrivial;
   } status_type;
endpackage

// ===== sv/mrwt_datapath.sv =====
module mrwt_datapath import mrwt_pkg::*; #(
   parameter int NUMBER_BITS = 62
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [NUMBER_BITS-1:0] n_in_val,
   input  logic [NUMBER_BITS-1:0] a_in_val,
   input  cmd_type                cmd,
   output status_type             status
);
   localparam int TW = $clog2(NUMBER_BITS + 1);
   localparam int W  = NUMBER_BITS + 1;

   logic [NUMBER_BITS-1:0] n_ff, x_ff, res_ff, sq_ff, cur_ff, prev_ff;
   logic [TW-1:0] twos_ff;
   logic [NUMBER_BITS-1:0] p_ff, q_ff, acc_ff, rem_ff;
   logic [TW-1:0] cnt_ff;
   logic [1:0] dst_ff;
   logic busy_ff, rbusy_ff;

   logic [W-1:0] acc_sum, acc_red, p_dbl, p_red, rem_sh, rem_red;
   logic [NUMBER_BITS-1:0] mul_res;

   always_comb begin
      acc_sum = {1'b0, acc_ff} + {1'b0, p_ff};
      acc_red = (acc_sum >= {1'b0, n_ff}) ? acc_sum - {1'b0, n_ff} : acc_sum;
      p_dbl   = {p_ff, 1'b0};
      p_red   = (p_dbl >= {1'b0, n_ff}) ? p_dbl - {1'b0, n_ff} : p_dbl;
      rem_sh  = {rem_ff, a_in_val[cnt_ff[TW-1:0]]};
      rem_red = (rem_sh >= {1'b0, n_ff}) ? rem_sh - {1'b0, n_ff} : rem_sh;
      mul_res = q_ff[0] ? acc_red[NUMBER_BITS-1:0] : acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         rbusy_ff <= 1'b0;
      end else begin
         unique case (cmd.op)
            OP_LOAD: begin
               n_ff    <= n_in_val;
               x_ff    <= n_in_val - NUMBER_BITS'(1);
               twos_ff <= '0;
            end
            OP_SHIFT: begin
               x_ff    <= x_ff >> 1;
               twos_ff <= twos_ff + TW'(1);
            end
            OP_REDUCE: begin
               rbusy_ff <= 1'b1;
               busy_ff  <= 1'b1;
               rem_ff   <= '0;
               cnt_ff   <= TW'(NUMBER_BITS - 1);
               res_ff   <= NUMBER_BITS'(1);
            end
            OP_MUL_RES, OP_MUL_SQ, OP_SQR_CUR: begin
               busy_ff <= 1'b1;
               acc_ff  <= '0;
               cnt_ff  <= TW'(NUMBER_BITS);
               unique case (cmd.op)
                  OP_MUL_RES: begin p_ff <= res_ff; q_ff <= sq_ff;  dst_ff <= 2'd0; end
                  OP_MUL_SQ:  begin p_ff <= sq_ff;  q_ff <= sq_ff;  dst_ff <= 2'd1; end
                  default:    begin p_ff <= cur_ff; q_ff <= cur_ff; dst_ff <= 2'd2;
                                    prev_ff <= cur_ff; end
               endcase
            end
            OP_TAKE_POW: begin
               cur_ff  <= res_ff;
               prev_ff <= res_ff;
            end
            OP_NONE: begin
               if (rbusy_ff) begin
                  rem_ff <= rem_red[NUMBER_BITS-1:0];
                  if (cnt_ff == '0) begin
                     rbusy_ff <= 1'b0;
                     busy_ff  <= 1'b0;
                     sq_ff    <= rem_red[NUMBER_BITS-1:0];
                  end else cnt_ff <= cnt_ff - TW'(1);
               end else if (busy_ff) begin
                  acc_ff <= mul_res;
                  p_ff   <= p_red[NUMBER_BITS-1:0];
                  q_ff   <= q_ff >> 1;
                  if (cnt_ff == TW'(1)) begin
                     busy_ff <= 1'b0;
                     unique case (dst_ff)
                        2'd0:    res_ff <= mul_res;
                        2'd1:    sq_ff  <= mul_res;
                        default: cur_ff <= mul_res;
                     endcase
                  end else cnt_ff <= cnt_ff - TW'(1);
               end
            end
            default: ;
         endcase
      end
   end

   assign status.mul_busy   = busy_ff;
   assign status.small_n    = (n_in_val < NUMBER_BITS'(2));
   assign status.n_is_two   = (n_in_val == NUMBER_BITS'(2));
   assign status.n_even     = ~n_in_val[0];
   assign status.x_odd      = x_ff[0];
   assign status.x_zero     = (x_ff == '0);
   assign status.twos_zero  = (twos_ff == '0);
   assign status.cur_is_one = (cur_ff == NUMBER_BITS'(1));
   assign status.nontrivial = (cur_ff == NUMBER_BITS'(1)) && (prev_ff != NUMBER_BITS'(1))
                              && (prev_ff != n_ff - NUMBER_BITS'(1));
endmodule

// ===== sv/mrwt_control.sv =====
module mrwt_control import mrwt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_verdict,
   output cmd_type    cmd,
   input  status_type status
);
`include "assert_macros.svh"
   localparam logic [3:0] S_IDLE = 4'd0, S_SPLIT = 4'd1, S_RED = 4'd2, S_POW = 4'd3,
      S_PWAIT = 4'd4, S_SQWAIT = 4'd5, S_FIN = 4'd6, S_SQR = 4'd7, S_SQRW = 4'd8,
      S_OUT = 4'd9, S_REDW = 4'd10, S_POWX = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [1:0] verdict_ff, verdict_in;
   logic [5:0] left_ff, left_in;
   logic [5:0] tcnt_ff, tcnt_in;

   // input stays held (valid until accepted); accept at the end
   assign req_ready   = (state_ff == S_OUT) && rsp_ready;
   assign rsp_valid   = (state_ff == S_OUT);
   assign rsp_verdict = verdict_ff;

   always_comb begin
      state_in   = state_ff;
      verdict_in = verdict_ff;
      left_in    = left_ff;
      tcnt_in    = tcnt_ff;
      cmd.op     = OP_NONE;
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            priority if (status.small_n) begin
               verdict_in = VERDICT_BELOW_TWO; state_in = S_OUT;
            end else if (status.n_is_two) begin
               verdict_in = VERDICT_TWO; state_in = S_OUT;
            end else if (status.n_even) begin
               verdict_in = VERDICT_COMPOSITE; state_in = S_OUT;
            end else begin
               cmd.op = OP_LOAD; state_in = S_SPLIT;
            end
         end
         S_SPLIT: if (status.x_odd) begin
            cmd.op = OP_REDUCE; state_in = S_REDW;
         end else cmd.op = OP_SHIFT;
         S_REDW: if (!status.mul_busy) state_in = S_POW;
         S_POW: if (status.x_zero) state_in = S_POWX;
            else if (status.x_odd) begin cmd.op = OP_MUL_RES; state_in = S_PWAIT; end
            else begin cmd.op = OP_MUL_SQ; state_in = S_SQWAIT; end
         S_PWAIT: if (!status.mul_busy) begin cmd.op = OP_MUL_SQ; state_in = S_SQWAIT; end
         S_SQWAIT: if (!status.mul_busy) begin cmd.op = OP_SHIFT; state_in = S_POW; end
         S_POWX: begin cmd.op = OP_TAKE_POW; state_in = S_FIN; end
         S_FIN: if (status.twos_zero) begin
            verdict_in = status.cur_is_one ? VERDICT_PROBABLE : VERDICT_COMPOSITE;
            state_in = S_OUT;
         end else begin
            tcnt_in = '0; state_in = S_SQR;
         end
         S_SQR: begin cmd.op = OP_SQR_CUR; state_in = S_SQRW; end
         S_SQRW: if (!status.mul_busy) begin
            if (status.nontrivial) begin
               verdict_in = VERDICT_COMPOSITE; state_in = S_OUT;
            end else if (tcnt_ff + 6'd1 == left_ff) begin
               verdict_in = status.cur_is_one ? VERDICT_PROBABLE : VERDICT_COMPOSITE;
               state_in = S_OUT;
            end else begin
               tcnt_in = tcnt_ff + 6'd1; state_in = S_SQR;
            end
         end
         S_OUT: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (cmd.op == OP_LOAD) left_in = '0;
      else if (cmd.op == OP_SHIFT && state_ff == S_SPLIT) left_in = left_ff + 6'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         left_ff  <= '0;
         tcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         left_ff  <= left_in;
         tcnt_ff  <= tcnt_in;
      end
      verdict_ff <= verdict_in;
   end

   `ASSERT_IMP(a_ready_only_out, clock, reset, req_ready, rsp_valid)
   `ASSERT_NEXT(a_out_leaves, clock, reset, rsp_valid && rsp_ready, state_ff == S_IDLE)
   `ASSERT_IMP(a_no_cmd_busy, clock, reset, status.mul_busy, cmd.op == OP_NONE)
endmodule

// ===== sv/miller_rabin_witness_test.sv =====
// channel | ports                               | dir
// req     | req_valid req_ready req_candidate req_witness_base | in
// rsp     | rsp_valid rsp_ready rsp_verdict     | out
// One word at a time. n below three or even: verdict from n alone, datapath idle.
// Odd n: each modular product and the base reduction run one bit a cycle
// (bit-serial shift-add).
// Request word is held until its verdict is taken (req_ready pulses with rsp).
// Reset: synchronous, active high, returns the controller to idle.
// Stalls on rsp hold the verdict; nothing else moves.
module miller_rabin_witness_test import mrwt_pkg::*; #(
   parameter int NUMBER_BITS = 62
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [61:0] req_candidate,
   input  logic [61:0] req_witness_base,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_verdict
);
   cmd_type    cmd;
   status_type status;

   mrwt_datapath #(.NUMBER_BITS(NUMBER_BITS)) u_dp (
      .clock, .reset,
      .n_in_val(req_candidate[NUMBER_BITS-1:0]),
      .a_in_val(req_witness_base[NUMBER_BITS-1:0]),
      .cmd, .status
   );

   mrwt_control u_ctl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .rsp_verdict, .cmd, .status
   );
endmodule

// ===== tb/tb_miller_rabin_witness_test.sv =====
`timescale 1ns / 100ps

module tb_miller_rabin_witness_test;
   import mrwt_pkg::*;

   localparam int NUM_RANDOM  = 100;
   localparam int CYCLE_LIMIT = 8000000;
   localparam int LONG_HOLD   = 400;

   typedef struct {
      logic [61:0] cand;
      logic [61:0] base;
      bit          drain;
   } test_word_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [61:0] req_candidate;
   logic [61:0] req_witness_base;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_verdict;

   test_word_type pending_words[$];
   logic [1:0]  expected_verdicts[$];
   int          total_words;
   int          sent_count;
   int          verdict_count;
   int          mismatch_count;
   int          composite_count;
   int          probable_count;
   int          cycle_count;
   int          send_gap;
   int          recv_gap;
   bit          long_hold_done;
   bit          stimulus_done;

   miller_rabin_witness_test dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_candidate    (req_candidate),
      .req_witness_base (req_witness_base),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_verdict      (rsp_verdict)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [63:0] mul_mod(logic [63:0] p, logic [63:0] q,
                                           logic [63:0] m);
      logic [63:0] acc;
      acc = 0;
      p = p % m;
      q = q % m;
      while (q != 0) begin
         if (q[0]) begin
            acc = acc + p;
            if (acc >= m) acc = acc - m;
         end
         p = p << 1;
         if (p >= m) p = p - m;
         q = q >> 1;
      end
      return acc;
   endfunction

   function automatic logic [63:0] pow_mod(logic [63:0] b, logic [63:0] e,
                                           logic [63:0] m);
      logic [63:0] acc;
      logic [63:0] sq;
      acc = 1 % m;
      sq = b % m;
      while (e != 0) begin
         if (e[0]) acc = mul_mod(acc, sq, m);
         sq = mul_mod(sq, sq, m);
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic logic [1:0] witness_verdict(logic [61:0] cand, logic [61:0] base);
      logic [63:0] n;
      logic [63:0] odd_part;
      logic [63:0] cur;
      logic [63:0] prev;
      int          twos;
      logic [1:0]  v;
      n = {2'b00, cand};
      if (n < 2) return VERDICT_BELOW_TWO;
      if (n == 2) return VERDICT_TWO;
      if (!n[0]) return VERDICT_COMPOSITE;
      odd_part = n - 1;
      twos = 0;
      while (!odd_part[0]) begin
         odd_part = odd_part >> 1;
         twos++;
      end
      cur = pow_mod({2'b00, base} % n, odd_part, n);
      prev = cur;
      v = VERDICT_PROBABLE;
      for (int i = 0; i < twos; i++) begin
         cur = mul_mod(cur, cur, n);
         if (cur == 1 && prev != 1 && prev != n - 1) begin
            v = VERDICT_COMPOSITE;
            break;
         end
         prev = cur;
      end
      if (v == VERDICT_PROBABLE && cur != 1) v = VERDICT_COMPOSITE;
      return v;
   endfunction

   function automatic logic [61:0] rand62();
      return {14'($urandom_range(16'h3fff, 0)), $urandom(),
              16'($urandom_range(16'hffff, 0))};
   endfunction

   task automatic add_word(logic [61:0] cand, logic [61:0] base, bit drain = 0);
      test_word_type w;
      w.cand = cand;
      w.base = base;
      w.drain = drain;
      pending_words.push_back(w);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_valid && req_ready) begin
            sent_count <= sent_count + 1;
         end
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_words.size() != 0 &&
                      !(pending_words[0].drain &&
                        (expected_verdicts.size() != 0 || (req_valid && req_ready)))) begin
            req_valid <= 1'b1;
            req_candidate <= pending_words[0].cand;
            req_witness_base <= pending_words[0].base;
            expected_verdicts.push_back(witness_verdict(pending_words[0].cand,
                                                        pending_words[0].base));
            void'(pending_words.pop_front());
            if (pending_words.size() > 15 && $urandom_range(3, 0) == 0)
               send_gap <= $urandom_range(14, 1);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap <= 0;
         long_hold_done <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            verdict_count <= verdict_count + 1;
            if (rsp_verdict == VERDICT_COMPOSITE) composite_count <= composite_count + 1;
            if (rsp_verdict == VERDICT_PROBABLE) probable_count <= probable_count + 1;
            if (expected_verdicts.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("unexpected verdict %0d", rsp_verdict);
            end else begin
               if (rsp_verdict !== expected_verdicts[0]) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display("verdict mismatch: expected %0d actual %0d",
                              expected_verdicts[0], rsp_verdict);
               end
               void'(expected_verdicts.pop_front());
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else if (!long_hold_done && verdict_count == 30) begin
            long_hold_done <= 1'b1;
            recv_gap <= LONG_HOLD;
            rsp_ready <= 1'b0;
         end else if (pending_words.size() > 15 && $urandom_range(5, 0) == 0) begin
            recv_gap <= $urandom_range(14, 1) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic [61:0] n;
      logic [61:0] primes[8];
      req_valid = 1'b0;
      req_candidate = '0;
      req_witness_base = '0;
      rsp_ready = 1'b0;
      reset = 1'b1;
      sent_count = 0;
      verdict_count = 0;
      mismatch_count = 0;
      composite_count = 0;
      probable_count = 0;
      cycle_count = 0;
      stimulus_done = 0;
      primes[0] = 62'd1000000007;
      primes[1] = 62'd998244353;
      primes[2] = 62'd2305843009213693951;
      primes[3] = 62'd1000000009;
      primes[4] = 62'd4294967291;
      primes[5] = 62'd3;
      primes[6] = 62'd65537;
      primes[7] = 62'd2147483647;

      // directed
      add_word(0, rand62());
      add_word(1, '1);
      add_word(2, 5);
      add_word(4, 3);
      add_word({{61{1'b1}}, 1'b0}, 7);
      add_word('1, '1);
      add_word('1, 0);
      add_word(3, 0);
      add_word(3, 2);
      add_word(7, 14);
      add_word(1000000007, 1);
      add_word(1000000007, 1000000006);
      add_word(62'd2305843009213693951, 62'd2305843009213693950);
      add_word(62'd2305843009213693951, rand62());
      add_word(561, 2);
      add_word(2047, 2);
      add_word(2047, 3);
      add_word(62'd998244353 * 62'd1000000007, 2);
      add_word(65537, 62'd65537 * 62'd12345);
      add_word(5, '1);
      add_word(9, 8, 1);

      for (int i = 0; i < NUM_RANDOM; i++) begin
         case ($urandom_range(5, 0))
            0: add_word(rand62() | 1, rand62(), i == 60);
            1: add_word(primes[$urandom_range(7, 0)], rand62(), i == 60);
            2: begin
               n = primes[$urandom_range(4, 0)] * primes[$urandom_range(7, 5)];
               add_word(n, rand62(), i == 60);
            end
            3: add_word($urandom_range(200, 0), rand62(), i == 60);
            4: begin
               n = primes[$urandom_range(7, 0)];
               add_word(n, $urandom_range(1, 0) ? n - 1 : n * $urandom_range(9, 1), i == 60);
            end
            default: add_word(rand62(), rand62(), i == 60);
         endcase
      end
      total_words = pending_words.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);

      $display("tested %0d candidates: %0d composite and %0d probable-prime verdicts",
               total_words, composite_count, probable_count);
      $display("%0d verdicts checked, %0d mismatches", verdict_count, mismatch_count);
      if (mismatch_count == 0 && expected_verdicts.size() == 0 && verdict_count == total_words)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
